@@ design/sptbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sptbl_pkg: shared types and codes for the sorted process table
// Record layout, operation codes and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package sptbl_pkg;

	// field widths of one record
	localparam int PID_W    = 16;
	localparam int BURST_W  = 16;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;
	localparam int ECNT_W   = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [PID_W-1:0]    pid;
		logic [BURST_W-1:0]  burst;
		logic [STATUS_W-1:0] status;
	} record_t;

	// broadcast to all cells during the execute cycle
	typedef struct packed {
		logic             insert_en;  // open a slot and drop the new record in
		logic             remove_en;  // close the slot of the first match
		logic [PID_W-1:0] key;
		record_t          new_rec;
	} cell_ctrl_t;

endpackage

@@ design/sptbl_cell.sv @@
// ----------------------------------------------------------------------------
// sptbl_cell: one slot of the sorted process table
// Holds one record, compares its pid with the broadcast key and shifts
// toward its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module sptbl_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  logic                 clk,
	input  sptbl_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]     count,
	input  sptbl_pkg::record_t   left_rec,
	input  sptbl_pkg::record_t   right_rec,
	input  logic                 left_lt,
	input  logic                 left_eq,
	output sptbl_pkg::record_t   rec,
	output logic                 lt,
	output logic                 eq,
	output logic                 first
);
	import sptbl_pkg::*;

	record_t rec_q;
	logic    occ;

	// slot holds a live record when it lies below the fill count
	assign occ   = CNT_W'(IDX) < count;
	assign lt    = occ && (rec_q.pid < ctrl.key);
	assign eq    = occ && (rec_q.pid == ctrl.key);
	// equal pids sit together, so the first match is where the run starts
	assign first = eq && !left_eq;
	assign rec   = rec_q;

	// insert: slots at or past the position take from the left, the position
	// itself takes the new record; remove: slots from the match on take from
	// the right
	always_ff @(posedge clk) begin
		if (ctrl.insert_en && !lt) begin
			rec_q <= left_lt ? ctrl.new_rec : left_rec;
		end else if (ctrl.remove_en && !lt) begin
			rec_q <= right_rec;
		end
	end

endmodule

@@ design/sorted_process_table.sv @@
// ----------------------------------------------------------------------------
// sorted_process_table: process records kept in ascending pid order
// Insert, find and remove on a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// An operation proceeds as follows: the command is captured on the
// transfer edge (start high, busy low), all cells compare their pid with the
// key and shift in the next cycle, and the result is shown with done high for
// exactly one cycle after that. busy is high only during the execute cycle,
// so a new command may be issued in the same cycle that done is high, but is
// not taken while busy is high. done cannot be held off: the receiver must
// take the result in that cycle. Reset empties the table at once.
module sorted_process_table #(
	parameter int CAPACITY = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [sptbl_pkg::OP_W-1:0]      opcode,
	input  logic [sptbl_pkg::PID_W-1:0]     key_pid,
	input  logic [sptbl_pkg::BURST_W-1:0]   burst_length,
	input  logic [sptbl_pkg::STATUS_W-1:0]  proc_status,
	output logic                            done,
	output logic                            success,
	output logic [sptbl_pkg::BURST_W-1:0]   found_burst,
	output logic [sptbl_pkg::STATUS_W-1:0]  found_status,
	output logic [sptbl_pkg::ECNT_W-1:0]    entry_count,
	output logic                            is_empty
);
	import sptbl_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// captured command
	logic                busy_q;
	logic [OP_W-1:0]     op_q;
	logic [PID_W-1:0]    key_q;
	logic [BURST_W-1:0]  burst_q;
	logic [STATUS_W-1:0] status_q;

	// table fill and result registers
	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	logic                success_q;
	logic [BURST_W-1:0]  found_burst_q;
	logic [STATUS_W-1:0] found_status_q;
	logic                is_empty_q;

	// cell row
	record_t             rec_w   [CAPACITY];
	logic [CAPACITY-1:0] lt_w;
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] first_w;
	cell_ctrl_t          ctrl;

	logic                full;
	logic                found;
	record_t             found_rec;
	logic                ins_ok;
	logic                find_ok;
	logic                rem_ok;
	logic [CNT_W-1:0]    count_nxt;

	logic                accept;

	assign accept = start && !busy_q;

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			key_q    <= key_pid;
			burst_q  <= burst_length;
			status_q <= proc_status;
		end
	end

	// match collection: at most one cell flags the first match
	always_comb begin
		found_rec = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_w[i]) begin
				found_rec = record_t'(found_rec | rec_w[i]);
			end
		end
	end

	assign found   = |first_w;
	assign full    = count_q == CNT_W'(CAPACITY);
	assign ins_ok  = busy_q && (op_q == OP_INSERT) && !full;
	assign find_ok = busy_q && (op_q == OP_FIND) && found;
	assign rem_ok  = busy_q && (op_q == OP_REMOVE) && found;

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// broadcast control
	assign ctrl.insert_en      = ins_ok;
	assign ctrl.remove_en      = rem_ok;
	assign ctrl.key            = key_q;
	assign ctrl.new_rec.pid    = key_q;
	assign ctrl.new_rec.burst  = burst_q;
	assign ctrl.new_rec.status = status_q;

	// row of cells, neighbors wired left and right
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		record_t l_rec;
		record_t r_rec;
		logic    l_lt;
		logic    l_eq;

		if (g == 0) begin : g_head
			assign l_rec = ctrl.new_rec;
			assign l_lt  = 1'b1;
			assign l_eq  = 1'b0;
		end else begin : g_body
			assign l_rec = rec_w[g-1];
			assign l_lt  = lt_w[g-1];
			assign l_eq  = eq_w[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign r_rec = rec_w[g];
		end else begin : g_mid
			assign r_rec = rec_w[g+1];
		end

		sptbl_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.left_rec  (l_rec),
			.right_rec (r_rec),
			.left_lt   (l_lt),
			.left_eq   (l_eq),
			.rec       (rec_w[g]),
			.lt        (lt_w[g]),
			.eq        (eq_w[g]),
			.first     (first_w[g])
		);
	end

	// control and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			count_q    <= '0;
			is_empty_q <= 1'b1;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
			end
			if (busy_q) begin
				count_q    <= count_nxt;
				is_empty_q <= count_nxt == '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy_q) begin
			success_q      <= ins_ok || find_ok || rem_ok;
			found_burst_q  <= (find_ok || rem_ok) ? found_rec.burst : '0;
			found_status_q <= (find_ok || rem_ok) ? found_rec.status : '0;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign success      = success_q;
	assign found_burst  = found_burst_q;
	assign found_status = found_status_q;
	assign entry_count  = ECNT_W'(count_q);
	assign is_empty     = is_empty_q;

	// execute lasts one cycle and is always followed by a result
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q && !busy_q)
		else $error("execute not followed by result");

	// fill count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	// fill count only moves on an execute cycle
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> $stable(count_q))
		else $error("fill count changed outside execute");

	// empty flag agrees with the fill count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty_q == (count_q == '0))
		else $error("empty flag disagrees with fill count");

	// at most one cell reports the first match
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(first_w))
		else $error("several first matches");

endmodule
